// ===== rtl/core/frsq_pkg.sv =====
// Shared types, constants and codes of the frame rate statistics and governor block.
package frsq_pkg;

    // Field widths.
    localparam int FT_W      = 20;
    localparam int FPS_W     = 16;
    localparam int RUNG_W    = 4;
    localparam int EV_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Default window depth of the frame time ring.
    localparam int WINDOW_DEPTH_DEF = 600;

    // Statistics constants.
    localparam logic [20:0] RECOMPUTE_US = 21'd250000;
    localparam int          MIN_SAMPLES  = 10;
    localparam logic [23:0] FPS_NUM      = 24'd16000000;
    localparam logic [15:0] FPS_MAX      = 16'hFFFF;

    // Reciprocal of 100 for the worst-frame count, exact below 43699.
    localparam logic [13:0] DIV100_MUL = 14'd5243;
    localparam int          DIV100_SH  = 19;

    // Rung event codes.
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_ENGAGE  = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BELOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABOVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNGS  = 3'd5;

    // Input item.
    typedef struct packed {
        logic [FT_W-1:0] frame_time_us;
        logic            governor_hold;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [FPS_W-1:0]  fps_current;
        logic [FPS_W-1:0]  fps_average;
        logic [FPS_W-1:0]  fps_one_percent_low;
        logic [RUNG_W-1:0] governor_rung;
        logic [EV_W-1:0]   rung_event;
        logic [RUNG_W-1:0] event_rung;
    } t_out_item;

    // Queue entry between the front and the back.
    typedef struct packed {
        logic [FT_W-1:0] frame_time_us;
        logic            governor_hold;
        logic            time_zero;
    } t_qent;

    // Configuration register set.
    typedef struct packed {
        logic              governor_enable;
        logic [FPS_W-1:0]  target_fps;
        logic [FPS_W-1:0]  hysteresis_fps;
        logic [31:0]       below_dwell_us;
        logic [31:0]       above_dwell_us;
        logic [RUNG_W-1:0] ladder_rungs;
    } t_cfg;

endpackage

// ===== rtl/core/frsq_front.sv =====
// Front part: accepts items, flags zero frame times and queues them for the back.
module frsq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  frsq_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    output frsq_pkg::t_qent   o_q_item,
    input  logic              i_q_pop
);
    import frsq_pkg::*;

    t_qent       r_buf [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    t_qent       new_ent;

    // Two-entry queue; stall only when both entries are occupied.
    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_buf[r_rd_ptr];

    // Classify the item as it enters.
    always_comb begin
        new_ent.frame_time_us = i_in_item.frame_time_us;
        new_ent.governor_hold = i_in_item.governor_hold;
        new_ent.time_zero     = (i_in_item.frame_time_us == '0);
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= new_ent;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/frsq_div.sv =====
// Shared restoring divider that turns a frame count and time sum into saturated fps.
module frsq_div #(
    parameter int SUM_W = 30,
    parameter int DW    = 47
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_num,
    input  logic [SUM_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [15:0]      o_quot
);
    import frsq_pkg::*;

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [15:0]   r_q;
    logic [3:0]    r_bit;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] den_sh;
    logic          ge;

    assign den_sh = DW'(i_den) << 16;
    assign ge     = (r_rem >= r_d);
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    // One quotient bit per cycle; zero divisor or overflow saturates at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || i_num >= den_sh) begin
                    r_q    <= FPS_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_num;
                    r_d    <= DW'(i_den) << 15;
                    r_q    <= '0;
                    r_bit  <= 4'd15;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? (r_rem - r_d) : r_rem;
                r_q   <= {r_q[14:0], ge};
                r_d   <= r_d >> 1;
                if (r_bit == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 4'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/frsq_back.sv =====
// Back part: frame ring, periodic statistics walk, governor and result register.
module frsq_back #(
    parameter int WINDOW_DEPTH = frsq_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  frsq_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  frsq_pkg::t_qent     i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    output frsq_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import frsq_pkg::*;

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = FT_W + CNT_W;
    localparam int DW      = SUM_W + 17;
    localparam int TOP_MAX = WINDOW_DEPTH / 100 + 1;
    localparam int KW      = $clog2(TOP_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CUR  = 4'd1;
    localparam logic [3:0] S_CURW = 4'd2;
    localparam logic [3:0] S_WALK = 4'd3;
    localparam logic [3:0] S_TSUM = 4'd4;
    localparam logic [3:0] S_AVG  = 4'd5;
    localparam logic [3:0] S_AVGW = 4'd6;
    localparam logic [3:0] S_LOW  = 4'd7;
    localparam logic [3:0] S_LOWW = 4'd8;
    localparam logic [3:0] S_GOV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]        r_state;
    logic [FT_W-1:0]   r_mem [WINDOW_DEPTH];
    logic [FT_W-1:0]   r_mem_q;
    logic [AW-1:0]     r_cursor;
    logic              r_full;
    logic [20:0]       r_timer;
    logic [FPS_W-1:0]  r_avg;
    logic [FPS_W-1:0]  r_low;
    logic [FPS_W-1:0]  r_cur;
    logic [31:0]       r_below;
    logic [31:0]       r_above;
    logic [RUNG_W-1:0] r_rung;
    logic [FT_W-1:0]   r_ft;
    logic              r_hold;
    logic              r_zero;
    logic              r_do_stats;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_v;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_worst;
    logic [FT_W-1:0]   r_top [TOP_MAX];
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_kc;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_item;

    // Divider hookup.
    logic              div_start;
    logic [DW-1:0]     div_num;
    logic [SUM_W-1:0]  div_den;
    logic [CNT_W-1:0]  div_cnt;
    logic              div_busy;
    logic              div_done;
    logic [15:0]       div_q;

    // Item intake values.
    logic [AW-1:0]     cur_next;
    logic              wrap;
    logic [20:0]       t_sum;
    logic              do_rc;
    logic [CNT_W-1:0]  n_calc;
    logic              rd_en;
    logic              walk_done;
    logic [FT_W-1:0]   top_ins [TOP_MAX];
    logic [TOP_MAX-1:0] gt;
    logic [CNT_W+13:0] kmul;
    logic [CNT_W-1:0]  kraw;
    logic [KW-1:0]     k_calc;

    // Governor next values.
    logic signed [17:0] lo;
    logic [16:0]        hi;
    logic               is_below;
    logic               is_above;
    logic [32:0]        b_add;
    logic [32:0]        a_add;
    logic [31:0]        b_sat;
    logic [31:0]        a_sat;
    logic [31:0]        n_below;
    logic [31:0]        n_above;
    logic [RUNG_W-1:0]  n_rung;
    logic [EV_W-1:0]    n_ev;
    logic [RUNG_W-1:0]  n_evr;
    logic               n_clr;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Cursor advance and recompute timer for the item being taken.
    assign wrap     = (r_cursor == AW'(WINDOW_DEPTH - 1));
    assign cur_next = wrap ? '0 : r_cursor + AW'(1);
    assign t_sum    = r_timer + 21'(i_q_item.frame_time_us);
    assign do_rc    = (t_sum >= RECOMPUTE_US);
    assign n_calc   = (r_full || wrap) ? CNT_W'(WINDOW_DEPTH) : CNT_W'(cur_next);

    // Walk control: one ring entry read per cycle, with the read data registered.
    assign rd_en     = (r_state == S_WALK) && (r_idx < r_n);
    assign walk_done = (r_state == S_WALK) && (r_idx == r_n) && !r_rd_v;

    // Worst-frame count: max(1, n/100), capped at the top list size.
    assign kmul = (CNT_W + 14)'(r_n) * (CNT_W + 14)'(DIV100_MUL);
    assign kraw = CNT_W'(kmul >> DIV100_SH);
    always_comb begin
        if (kraw == '0) begin
            k_calc = KW'(1);
        end else if (kraw > CNT_W'(TOP_MAX)) begin
            k_calc = KW'(TOP_MAX);
        end else begin
            k_calc = KW'(kraw);
        end
    end

    // Sorted insertion of the read value into the descending top list.
    always_comb begin
        for (int j = 0; j < TOP_MAX; j++) begin
            gt[j] = (r_mem_q > r_top[j]);
        end
        for (int j = 0; j < TOP_MAX; j++) begin
            if (!gt[j]) begin
                top_ins[j] = r_top[j];
            end else if (j == 0) begin
                top_ins[j] = r_mem_q;
            end else if (gt[j-1]) begin
                top_ins[j] = r_top[j-1];
            end else begin
                top_ins[j] = r_mem_q;
            end
        end
    end

    // Divider operands by state.
    always_comb begin
        div_start = 1'b0;
        div_cnt   = CNT_W'(1);
        div_den   = SUM_W'(r_ft);
        case (r_state)
            S_CUR: begin
                div_start = !r_zero;
            end
            S_AVG: begin
                div_start = 1'b1;
                div_cnt   = r_n;
                div_den   = r_sum;
            end
            S_LOW: begin
                div_start = 1'b1;
                div_cnt   = CNT_W'(r_k);
                div_den   = r_worst;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
        div_num = DW'(FPS_NUM) * DW'(div_cnt) + DW'(div_den >> 1);
    end

    frsq_div #(
        .SUM_W (SUM_W),
        .DW    (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Governor decision against the dead band.
    always_comb begin
        lo       = $signed({2'b00, i_cfg.target_fps}) - $signed({2'b00, i_cfg.hysteresis_fps});
        hi       = {1'b0, i_cfg.target_fps} + {1'b0, i_cfg.hysteresis_fps};
        is_below = $signed({2'b00, r_avg}) < lo;
        is_above = {1'b0, r_avg} > hi;
        b_add    = {1'b0, r_below} + 33'(r_ft);
        a_add    = {1'b0, r_above} + 33'(r_ft);
        b_sat    = b_add[32] ? '1 : b_add[31:0];
        a_sat    = a_add[32] ? '1 : a_add[31:0];
        n_below  = r_below;
        n_above  = r_above;
        n_rung   = r_rung;
        n_ev     = EV_NONE;
        n_evr    = '0;
        n_clr    = 1'b0;
        if (i_cfg.governor_enable && !r_hold && r_avg != '0) begin
            if (is_below) begin
                n_above = '0;
                n_below = b_sat;
                if (b_sat >= i_cfg.below_dwell_us && r_rung < i_cfg.ladder_rungs) begin
                    n_ev    = EV_ENGAGE;
                    n_evr   = r_rung;
                    n_rung  = r_rung + RUNG_W'(1);
                    n_below = '0;
                    n_clr   = 1'b1;
                end
            end else if (is_above) begin
                n_below = '0;
                n_above = a_sat;
                if (a_sat >= i_cfg.above_dwell_us && r_rung != '0) begin
                    n_ev    = EV_RELEASE;
                    n_evr   = r_rung - RUNG_W'(1);
                    n_rung  = r_rung - RUNG_W'(1);
                    n_above = '0;
                    n_clr   = 1'b1;
                end
            end else begin
                n_below = '0;
                n_above = '0;
            end
        end
    end

    // Frame ring memory: one write port at intake, one registered read port.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mem[r_cursor] <= i_q_item.frame_time_us;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Sequencer and statistics datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_full      <= 1'b0;
            r_timer     <= '0;
            r_avg       <= '0;
            r_low       <= '0;
            r_below     <= '0;
            r_above     <= '0;
            r_rung      <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result empties the register, unless S_OUT refills it this cycle.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ft       <= i_q_item.frame_time_us;
                        r_hold     <= i_q_item.governor_hold;
                        r_zero     <= i_q_item.time_zero;
                        r_cursor   <= cur_next;
                        if (wrap) begin
                            r_full <= 1'b1;
                        end
                        r_timer    <= do_rc ? '0 : t_sum;
                        r_n        <= n_calc;
                        r_do_stats <= do_rc && (n_calc > CNT_W'(MIN_SAMPLES));
                        r_state    <= S_CUR;
                    end
                end
                S_CUR: begin
                    if (r_zero) begin
                        r_cur <= '0;
                    end
                    r_state <= r_zero ? S_CURW : S_CURW;
                end
                S_CURW: begin
                    if (div_done || r_zero) begin
                        if (!r_zero) begin
                            r_cur <= div_q;
                        end
                        if (r_do_stats) begin
                            r_idx   <= '0;
                            r_rd_v  <= 1'b0;
                            r_sum   <= '0;
                            r_k     <= k_calc;
                            for (int j = 0; j < TOP_MAX; j++) begin
                                r_top[j] <= '0;
                            end
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_GOV;
                        end
                    end
                end
                S_WALK: begin
                    r_rd_v <= rd_en;
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_rd_v) begin
                        r_sum <= r_sum + SUM_W'(r_mem_q);
                        for (int j = 0; j < TOP_MAX; j++) begin
                            r_top[j] <= top_ins[j];
                        end
                    end
                    if (walk_done) begin
                        r_kc    <= r_k;
                        r_worst <= '0;
                        r_state <= S_TSUM;
                    end
                end
                S_TSUM: begin
                    if (r_kc != '0) begin
                        r_worst <= r_worst + SUM_W'(r_top[0]);
                        for (int j = 0; j < TOP_MAX - 1; j++) begin
                            r_top[j] <= r_top[j+1];
                        end
                        r_kc <= r_kc - KW'(1);
                    end else begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_state <= S_AVGW;
                end
                S_AVGW: begin
                    if (div_done) begin
                        r_avg   <= div_q;
                        r_state <= S_LOW;
                    end
                end
                S_LOW: begin
                    r_state <= S_LOWW;
                end
                S_LOWW: begin
                    if (div_done) begin
                        r_low   <= div_q;
                        r_state <= S_GOV;
                    end
                end
                S_GOV: begin
                    r_below <= n_below;
                    r_above <= n_above;
                    r_rung  <= n_rung;
                    if (n_clr) begin
                        r_cursor <= '0;
                        r_full   <= 1'b0;
                    end
                    r_res.fps_current         <= r_cur;
                    r_res.fps_average         <= r_avg;
                    r_res.fps_one_percent_low <= r_low;
                    r_res.governor_rung       <= n_rung;
                    r_res.rung_event          <= n_ev;
                    r_res.event_rung          <= n_evr;
                    r_state                   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A rung change empties the ring.
    a_clr_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GOV && n_ev != EV_NONE) |=> (r_cursor == '0 && !r_full))
        else $error("ring not cleared after rung change");

    // The shared divider is never restarted while it is working.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // An item without a rung event reports rung index zero.
    a_no_event_rung: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.rung_event == EV_NONE) |-> (r_out_item.event_rung == '0))
        else $error("event rung set without an event");

    // The walk never reads past the held samples.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_n))
        else $error("walk index past sample count");
`endif

endmodule

// ===== rtl/core/frame_rate_stats_and_quality_governor_top.sv =====
// Top level of the frame rate statistics and quality governor with its register set.
// Per item, the current fps is computed first; an item that triggers a statistics pass then walks the
// ring over its N held frames, sums the k worst frames and divides out the average and the low.
// Throughput: one item in work at a time; a two-item queue and the result register
// decouple both sides. Fps values use the shared divider; a zero frame time gives current fps 0.
// Reset: synchronous; control state and statistics clear, registers take defaults.
module frame_rate_stats_and_quality_governor_top #(
    parameter int WINDOW_DEPTH = frsq_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  frsq_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output frsq_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [frsq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [frsq_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import frsq_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid;
    t_qent q_item;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.governor_enable <= 1'b1;
            r_cfg.target_fps      <= 16'd960;
            r_cfg.hysteresis_fps  <= 16'd80;
            r_cfg.below_dwell_us  <= 32'd3000000;
            r_cfg.above_dwell_us  <= 32'd10000000;
            r_cfg.ladder_rungs    <= 4'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_cfg.governor_enable <= i_cfg_data[0];
                CFG_TARGET: r_cfg.target_fps      <= i_cfg_data[FPS_W-1:0];
                CFG_HYST:   r_cfg.hysteresis_fps  <= i_cfg_data[FPS_W-1:0];
                CFG_BELOW:  r_cfg.below_dwell_us  <= i_cfg_data;
                CFG_ABOVE:  r_cfg.above_dwell_us  <= i_cfg_data;
                CFG_RUNGS:  r_cfg.ladder_rungs    <= i_cfg_data[RUNG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    frsq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    frsq_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
